FILE: design/apbi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apbi_pkg
// Shared constants, codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package apbi_pkg;

  localparam int MAX_PHI_POINTS   = 64;
  localparam int MAX_THETA_POINTS = 64;
  localparam int PIDX_W = $clog2(MAX_PHI_POINTS);
  localparam int TIDX_W = $clog2(MAX_THETA_POINTS);
  localparam int SIDX_W = PIDX_W + TIDX_W;

  localparam logic [1:0] CMD_QUERY  = 2'd0;
  localparam logic [1:0] CMD_PHI    = 2'd1;
  localparam logic [1:0] CMD_THETA  = 2'd2;
  localparam logic [1:0] CMD_SAMPLE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LOADED  = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;
  localparam logic [1:0] ST_BADIDX  = 2'd3;

  localparam logic [6:0] REG_PHI_COUNT   = 7'd0;
  localparam logic [6:0] REG_THETA_COUNT = 7'd1;

  function automatic logic signed [17:0] atan_lut(input logic [3:0] i);
    logic signed [17:0] r;
    case (i)
      4'd0:    r = 18'sd51472;
      4'd1:    r = 18'sd30386;
      4'd2:    r = 18'sd16055;
      4'd3:    r = 18'sd8150;
      4'd4:    r = 18'sd4091;
      4'd5:    r = 18'sd2047;
      4'd6:    r = 18'sd1024;
      4'd7:    r = 18'sd512;
      4'd8:    r = 18'sd256;
      4'd9:    r = 18'sd128;
      4'd10:   r = 18'sd64;
      4'd11:   r = 18'sd32;
      4'd12:   r = 18'sd16;
      4'd13:   r = 18'sd8;
      4'd14:   r = 18'sd4;
      default: r = 18'sd2;
    endcase
    return r;
  endfunction

endpackage

FILE: design/apbi_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apbi_cordic
// Iterative sin/cos of a Q4.16 angle, one rotation per cycle, Q1.16 out.
// ----------------------------------------------------------------------------
module apbi_cordic
  import apbi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [19:0] angle,
  output logic               done,
  output logic signed [17:0] sin_q,
  output logic signed [17:0] cos_q
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RED  = 2'd1;
  localparam logic [1:0] C_ROT  = 2'd2;
  localparam logic [1:0] C_OUT  = 2'd3;

  logic [1:0] state;
  logic [3:0] iter;
  logic signed [21:0] z;
  logic signed [33:0] x, y;
  logic neg;
  logic signed [33:0] xs, ys, xr, yr;
  logic signed [17:0] xc, yc;

  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign xr = (x + 34'sd8192) >>> 14;
  assign yr = (y + 34'sd8192) >>> 14;
  assign xc = (xr > 34'sd65536) ? 18'sd65536 :
              (xr < -34'sd65536) ? -18'sd65536 : xr[17:0];
  assign yc = (yr > 34'sd65536) ? 18'sd65536 :
              (yr < -34'sd65536) ? -18'sd65536 : yr[17:0];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= C_IDLE;
    end else begin
      case (state)
        C_IDLE: begin
          if (start) begin
            z     <= 22'(angle);
            neg   <= 1'b0;
            state <= C_RED;
          end
        end
        C_RED: begin
          // at most one 2pi step for a 20-bit angle, then the pi fold
          if (z > 22'sd205887) z <= z - 22'sd411775;
          else if (z < -22'sd205887) z <= z + 22'sd411775;
          else begin
            if (z > 22'sd102944) begin
              z <= z - 22'sd205887; neg <= 1'b1;
            end else if (z < -22'sd102944) begin
              z <= z + 22'sd205887; neg <= 1'b1;
            end
            x     <= 34'sd652032874;
            y     <= '0;
            iter  <= '0;
            state <= C_ROT;
          end
        end
        C_ROT: begin
          if (z >= 0) begin
            x <= x - ys; y <= y + xs; z <= z - 22'(atan_lut(iter));
          end else begin
            x <= x + ys; y <= y - xs; z <= z + 22'(atan_lut(iter));
          end
          iter <= iter + 4'd1;
          if (iter == 4'd15) state <= C_OUT;
        end
        C_OUT: begin
          cos_q <= neg ? -xc : xc;
          sin_q <= neg ? -yc : yc;
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

FILE: design/apbi_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apbi_divider
// Restoring divider for the Q0.16 fraction: (num << 16) / den, 16 steps.
// ----------------------------------------------------------------------------
module apbi_divider
  import apbi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [20:0] num,
  input  logic [20:0] den,
  output logic        done,
  output logic [15:0] quo
);

  logic        busy;
  logic [4:0]  cnt;
  logic [21:0] rem;
  logic [20:0] dreg;
  logic [15:0] q;
  logic [21:0] trial;

  // num < den always holds for a valid bracket, so the quotient fits 16 bits
  assign trial = {rem[20:0], 1'b0};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= {1'b0, num};
      dreg <= den;
      cnt  <= '0;
      q    <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, dreg}) begin
        rem <= trial - {1'b0, dreg};
        q   <= {q[14:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[14:0], 1'b0};
      end
      cnt <= cnt + 5'd1;
      if (cnt == 5'd15) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb quo = q;

endmodule

FILE: design/antenna_pattern_bilinear_interp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// antenna_pattern_bilinear_interp_unit
// Tabulated antenna pattern with bilinear lookup and unit vectors.
// ----------------------------------------------------------------------------
// Input transfers on s_axis: tuser carries cmd, tdata the angles, slots and
// sample pair. Each input gives exactly one output transfer on m_axis.
// Loads (phi axis, theta axis, sample pair) write the axis or sample memories
// at the input transfer; the S_DONE state then sets the output valid. A
// query scans both axes (one entry per cycle, stopping at the bracket), runs
// two 16-step divisions for the fractions, reads the four grid corners (one
// per cycle) and runs 12 lerps, while a CORDIC computes sin/cos of both
// angles. For a query that finds its cell, the axis scans and the divisions
// set when the result is offered. A query outside the table ends after its
// scans or the two CORDIC runs, whichever is later. One item is in work at a
// time; the next input transfer can follow in the cycle after the output one.
// The output register holds a result until m_axis_tready; s_axis_tready is
// low while a result waits or an item is in work.
// Reset clears control state and the counts (to 2); memory contents are
// undefined until loaded, and no clearing pass is made.
// ----------------------------------------------------------------------------
module antenna_pattern_bilinear_interp_unit
  import apbi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // phi_angle, theta_angle, phi_slot, theta_slot, load_theta_re,
  // load_theta_im, load_phi_re, load_phi_im, zero fill
  input  logic [151:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,    // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_theta_re, out_theta_im, out_phi_re, out_phi_im, tvec_x, tvec_y,
  // tvec_z, pvec_x, pvec_y, zero fill
  output logic [191:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,    // status
  input  logic         cfg_we,
  input  logic [6:0]   cfg_index,
  input  logic [6:0]   cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PSCAN = 4'd1;
  localparam logic [3:0] S_TSCAN = 4'd2;
  localparam logic [3:0] S_PDIV  = 4'd3;
  localparam logic [3:0] S_TDIV  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_LERP  = 4'd6;
  localparam logic [3:0] S_WAITC = 4'd7;
  localparam logic [3:0] S_VEC   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [6:0] phi_count, theta_count;
  logic [6:0] np, nt;

  always_ff @(posedge clk) begin
    if (rst) begin
      phi_count   <= 7'd2;
      theta_count <= 7'd2;
    end else if (cfg_we) begin
      if (cfg_index == REG_PHI_COUNT) phi_count <= cfg_data;
      else if (cfg_index == REG_THETA_COUNT) theta_count <= cfg_data;
    end
  end

  assign np = (phi_count < 7'd2) ? 7'd2 :
              (phi_count > 7'(MAX_PHI_POINTS)) ? 7'(MAX_PHI_POINTS) : phi_count;
  assign nt = (theta_count < 7'd2) ? 7'd2 :
              (theta_count > 7'(MAX_THETA_POINTS)) ? 7'(MAX_THETA_POINTS) : theta_count;

  // input unpack
  logic [1:0]         in_cmd;
  logic signed [19:0] in_pa, in_ta;
  logic [5:0]         in_ps, in_ts;
  assign in_cmd = s_axis_tuser;
  assign in_pa  = s_axis_tdata[19:0];
  assign in_ta  = s_axis_tdata[39:20];
  assign in_ps  = s_axis_tdata[45:40];
  assign in_ts  = s_axis_tdata[51:46];

  // memories
  logic signed [19:0] phi_axis   [MAX_PHI_POINTS];
  logic signed [19:0] theta_axis [MAX_THETA_POINTS];
  logic [47:0] theta_samples [MAX_PHI_POINTS*MAX_THETA_POINTS];
  logic [47:0] phi_samples   [MAX_PHI_POINTS*MAX_THETA_POINTS];

  logic [3:0]  state;
  logic        m_valid;
  logic [1:0]  status;
  logic signed [19:0] pa, ta;
  logic [6:0]  scan;
  logic [PIDX_W-1:0] pax_addr;
  logic [TIDX_W-1:0] tax_addr;
  logic signed [19:0] pax_q, tax_q, prev;
  logic        scan_first;
  logic [PIDX_W-1:0] pidx;
  logic [TIDX_W-1:0] tidx;
  logic signed [19:0] p_lo, p_hi, t_lo, t_hi;
  logic        outside;

  logic        pax_we, tax_we, smp_we;
  logic [SIDX_W-1:0] smp_waddr, smp_raddr;
  logic [47:0] ts_q, ps_q;

  always_ff @(posedge clk) begin
    if (pax_we) phi_axis[in_ps[PIDX_W-1:0]] <= in_pa;
    if (tax_we) theta_axis[in_ts[TIDX_W-1:0]] <= in_ta;
    pax_q <= phi_axis[pax_addr];
    tax_q <= theta_axis[tax_addr];
  end

  // sample words: real part in the upper half, imaginary in the lower
  always_ff @(posedge clk) begin
    if (smp_we) begin
      theta_samples[smp_waddr] <= {s_axis_tdata[75:52], s_axis_tdata[99:76]};
      phi_samples[smp_waddr]   <= {s_axis_tdata[123:100], s_axis_tdata[147:124]};
    end
    ts_q <= theta_samples[smp_raddr];
    ps_q <= phi_samples[smp_raddr];
  end

  logic accept;
  assign s_axis_tready = (state == S_IDLE) && !m_valid;
  assign accept = s_axis_tvalid && s_axis_tready;

  assign pax_we = accept && in_cmd == CMD_PHI && {1'b0, in_ps} < np;
  assign tax_we = accept && in_cmd == CMD_THETA && {1'b0, in_ts} < nt;
  assign smp_we = accept && in_cmd == CMD_SAMPLE &&
                  {1'b0, in_ps} < np && {1'b0, in_ts} < nt;
  assign smp_waddr = {in_ps[PIDX_W-1:0], in_ts[TIDX_W-1:0]};

  // scan address: during a scan step, address for next cycle's read
  assign pax_addr = (state == S_PSCAN) ? scan[PIDX_W-1:0] : pidx;
  assign tax_addr = (state == S_TSCAN) ? scan[TIDX_W-1:0] : tidx;

  // corner reads: 0 (p,t) 1 (p,t+1) 2 (p+1,t) 3 (p+1,t+1)
  logic [2:0] rd;
  logic [1:0] rdm;
  logic [PIDX_W-1:0] rp;
  logic [TIDX_W-1:0] rt;
  assign rp = pidx + PIDX_W'(rd[1]);
  assign rt = tidx + TIDX_W'(rd[0]);
  assign smp_raddr = {rp, rt};
  assign rdm = 2'(rd - 3'd1);

  // cordic
  logic cs_start, cs_done;
  logic signed [19:0] cs_ang;
  logic signed [17:0] cs_sin, cs_cos;
  logic signed [17:0] sp, cp, st, ct;
  logic [1:0] cs_phase;

  apbi_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cs_start), .angle(cs_ang),
    .done(cs_done), .sin_q(cs_sin), .cos_q(cs_cos)
  );

  // divider
  logic dv_start, dv_done;
  logic [20:0] dv_num, dv_den;
  logic [15:0] dv_quo;
  logic [15:0] pu, tu;

  apbi_divider u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo)
  );

  logic signed [20:0] pnum, pden, tnum, tden;
  assign pnum = 21'(pa) - 21'(p_lo);
  assign pden = 21'(p_hi) - 21'(p_lo);
  assign tnum = 21'(ta) - 21'(t_lo);
  assign tden = 21'(t_hi) - 21'(t_lo);
  assign dv_num = (state == S_PDIV) ? pnum : tnum;
  assign dv_den = (state == S_PDIV) ? pden : tden;

  // interpolation: corners stored, then lerps in turn via one shared multiplier
  logic signed [23:0] cr [4];
  logic signed [23:0] ci [4];
  logic signed [23:0] cpr [4];
  logic signed [23:0] cpi [4];
  logic signed [23:0] lo_v, hi_v;
  logic [3:0]  lstep;
  logic signed [23:0] la, lb;
  logic [15:0] ls;
  logic signed [24:0] ldiff;
  logic signed [41:0] lprod;
  logic signed [23:0] lres;
  logic signed [23:0] o_tr, o_ti, o_pr, o_pi;

  always_comb begin
    la = '0; lb = '0; ls = tu;
    case (lstep)
      4'd0:  begin la = cr[0];  lb = cr[1];  end
      4'd1:  begin la = cr[2];  lb = cr[3];  end
      4'd2:  begin la = lo_v;   lb = hi_v;   ls = pu; end
      4'd3:  begin la = ci[0];  lb = ci[1];  end
      4'd4:  begin la = ci[2];  lb = ci[3];  end
      4'd5:  begin la = lo_v;   lb = hi_v;   ls = pu; end
      4'd6:  begin la = cpr[0]; lb = cpr[1]; end
      4'd7:  begin la = cpr[2]; lb = cpr[3]; end
      4'd8:  begin la = lo_v;   lb = hi_v;   ls = pu; end
      4'd9:  begin la = cpi[0]; lb = cpi[1]; end
      4'd10: begin la = cpi[2]; lb = cpi[3]; end
      4'd11: begin la = lo_v;   lb = hi_v;   ls = pu; end
      default: begin la = '0; lb = '0; end
    endcase
    ldiff = 25'(lb) - 25'(la);
    lprod = 42'(ldiff) * $signed({1'b0, ls});
    lres  = la + 24'(lprod >>> 16);
  end

  // vectors: the two products share one multiplier, selected by vphase
  logic signed [35:0] vprod;
  logic signed [17:0] vx, vy;
  logic        vphase;
  logic signed [35:0] vround;
  assign vprod  = (vphase ? ct * sp : ct * cp);
  assign vround = (vprod + 36'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    cs_start <= 1'b0;
    dv_start <= 1'b0;
    if (rst) begin
      state   <= S_IDLE;
      m_valid <= 1'b0;
      cs_phase <= '0;
    end else begin
      if (m_valid && m_axis_tready) m_valid <= 1'b0;
      // cordic sequencing: phi then theta
      if (cs_done) begin
        if (cs_phase == 2'd1) begin
          sp <= cs_sin; cp <= cs_cos;
          cs_ang <= ta; cs_start <= 1'b1; cs_phase <= 2'd2;
        end else begin
          st <= cs_sin; ct <= cs_cos; cs_phase <= 2'd3;
        end
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pa <= in_pa; ta <= in_ta;
            o_tr <= '0; o_ti <= '0; o_pr <= '0; o_pi <= '0;
            vx <= '0; vy <= '0; st <= '0; sp <= '0; cp <= '0;
            if (in_cmd == CMD_QUERY) begin
              cs_ang <= in_pa; cs_start <= 1'b1; cs_phase <= 2'd1;
              scan <= '0; scan_first <= 1'b1; outside <= 1'b0;
              state <= S_PSCAN;
            end else begin
              if (in_cmd == CMD_PHI) status <= pax_we ? ST_LOADED : ST_BADIDX;
              else if (in_cmd == CMD_THETA) status <= tax_we ? ST_LOADED : ST_BADIDX;
              else status <= smp_we ? ST_LOADED : ST_BADIDX;
              cs_phase <= 2'd0;
              state <= S_DONE;
            end
          end
        end
        S_PSCAN: begin
          // pax_q holds entry scan-1 while scan advances
          if (!scan_first) begin
            if (pax_q > pa) begin
              if (scan == 7'd1) outside <= 1'b1;
              p_hi <= pax_q; p_lo <= prev;
              pidx <= PIDX_W'(scan - 7'd2);
              scan <= '0; scan_first <= 1'b1;
              state <= S_TSCAN;
            end else if (scan == np) begin
              outside <= 1'b1; state <= S_WAITC;
            end else begin
              scan <= scan + 7'd1;
            end
            prev <= pax_q;
          end else begin
            scan <= scan + 7'd1; scan_first <= 1'b0;
          end
        end
        S_TSCAN: begin
          if (!scan_first) begin
            if (tax_q > ta) begin
              if (scan == 7'd1 || outside) begin
                outside <= 1'b1; state <= S_WAITC;
              end else begin
                t_hi <= tax_q; t_lo <= prev;
                tidx <= TIDX_W'(scan - 7'd2);
                dv_start <= 1'b1;
                state <= S_PDIV;
              end
            end else if (scan == nt) begin
              outside <= 1'b1; state <= S_WAITC;
            end else begin
              scan <= scan + 7'd1;
            end
            prev <= tax_q;
          end else begin
            scan <= scan + 7'd1; scan_first <= 1'b0;
          end
        end
        S_PDIV: begin
          if (dv_done && !dv_start) begin
            pu <= dv_quo; dv_start <= 1'b1; state <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (dv_done && !dv_start) begin
            tu <= dv_quo; rd <= '0; state <= S_RD;
          end
        end
        S_RD: begin
          // data of address rd-1 arrives this cycle
          if (rd != 3'd0) begin
            cr[rdm]  <= ts_q[47:24]; ci[rdm]  <= ts_q[23:0];
            cpr[rdm] <= ps_q[47:24]; cpi[rdm] <= ps_q[23:0];
          end
          if (rd == 3'd4) begin
            lstep <= '0; state <= S_LERP;
          end else begin
            rd <= rd + 3'd1;
          end
        end
        S_LERP: begin
          case (lstep)
            4'd0, 4'd3, 4'd6, 4'd9:  lo_v <= lres;
            4'd1, 4'd4, 4'd7, 4'd10: hi_v <= lres;
            4'd2:  o_tr <= lres;
            4'd5:  o_ti <= lres;
            4'd8:  o_pr <= lres;
            default: o_pi <= lres;
          endcase
          if (lstep == 4'd11) state <= S_WAITC;
          else lstep <= lstep + 4'd1;
        end
        S_WAITC: begin
          if (cs_phase == 2'd3) begin
            vphase <= 1'b0; state <= S_VEC;
          end
        end
        S_VEC: begin
          if (!vphase) vx <= vround[17:0];
          else vy <= vround[17:0];
          vphase <= 1'b1;
          if (vphase) begin
            status <= outside ? ST_OUTSIDE : ST_OK;
            if (outside) begin
              o_tr <= '0; o_ti <= '0; o_pr <= '0; o_pi <= '0;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          m_valid <= 1'b1;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic signed [17:0] tz, px, py;
  assign tz = -st;
  assign px = -sp;
  assign py = cp;

  assign m_axis_tvalid = m_valid;
  assign m_axis_tuser  = status;
  assign m_axis_tdata  = {6'd0, py, px, tz, vy, vx, o_pi, o_pr, o_ti, o_tr};

endmodule
